### rtl/pid_pkg.sv
package pid_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Stream payload widths
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 32;

    // Shared divider: dividend, quotient and saturated result widths
    localparam int DIV_NW = 86;
    localparam int DIV_QW = 52;
    localparam int DIV_RW = 51;

    // Integral increment is scaled by 32/15625, derivative by 62500
    localparam logic [31:0] INT_DIVISOR = 32'd15625;
    localparam logic [31:0] DER_SCALE   = 32'd62500;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P      = 3'd0,
        REG_GAIN_I      = 3'd1,
        REG_GAIN_D      = 3'd2,
        REG_TARGET_TEMP = 3'd3,
        REG_OUT_LOW     = 3'd4,
        REG_OUT_HIGH    = 3'd5,
        REG_INT_LOW     = 3'd6,
        REG_INT_HIGH    = 3'd7
    } pid_reg_t;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_LOAD    = 4'd1,
        OP_PREP    = 4'd2,
        OP_MUL_P   = 4'd3,
        OP_MUL_S   = 4'd4,
        OP_MUL_ILO = 4'd5,
        OP_MUL_IHI = 4'd6,
        OP_DIV_I   = 4'd7,
        OP_ACC     = 4'd8,
        OP_MUL_D   = 4'd9,
        OP_MUL_DLO = 4'd10,
        OP_MUL_DHI = 4'd11,
        OP_DIV_D   = 4'd12,
        OP_SUM     = 4'd13,
        OP_OUT     = 4'd14
    } pid_op_t;

    typedef struct packed {
        pid_op_t op;
    } pid_cmd_t;

    typedef struct packed {
        logic div_done;
        logic dt_zero;
        logic out_free;
    } pid_stat_t;

endpackage

### rtl/pid_div.sv
module pid_div import pid_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic              deriv,
    input  logic [DIV_NW-1:0] dividend,
    input  logic [31:0]       divisor,
    output logic              busy,
    output logic              done,
    output logic [DIV_RW-1:0] quot
);

    // Integral run takes 52 quotient bits, derivative run 46, two bits a cycle
    localparam int I_SHIFT = DIV_NW - DIV_QW;
    localparam int D_SHIFT = DIV_NW - 46;
    localparam int HI_W    = D_SHIFT;
    localparam logic [4:0] I_STEPS = 5'd26;
    localparam logic [4:0] D_STEPS = 5'd23;
    localparam logic [DIV_RW-1:0] I_LIM = DIV_RW'(1) << 50;
    localparam logic [DIV_RW-1:0] D_LIM = DIV_RW'(1) << 44;

    logic              busy_reg;
    logic              done_reg;
    logic [4:0]        cnt_reg;
    logic [31:0]       rem_reg;
    logic [DIV_NW-1:0] sh_reg;
    logic [DIV_QW-1:0] q_reg;
    logic              ovf_reg;
    logic              deriv_reg;
    logic [31:0]       dvs_reg;

    logic [HI_W-1:0] hi_sel;
    logic            ovf_start;
    logic [32:0]     t1, t2, r1, r2;
    logic            ge1, ge2;
    logic [DIV_RW-1:0] lim;

    // Part of the dividend above the first quotient bit
    assign hi_sel = deriv ? dividend[DIV_NW-1 -: HI_W]
                          : {{(HI_W-I_SHIFT){1'b0}}, dividend[DIV_NW-1 -: I_SHIFT]};
    assign ovf_start = hi_sel >= {{(HI_W-32){1'b0}}, divisor};

    // Two restoring steps per cycle
    always_comb begin
        t1  = {rem_reg, sh_reg[DIV_NW-1]};
        ge1 = t1 >= {1'b0, dvs_reg};
        r1  = ge1 ? t1 - {1'b0, dvs_reg} : t1;
        t2  = {r1[31:0], sh_reg[DIV_NW-2]};
        ge2 = t2 >= {1'b0, dvs_reg};
        r2  = ge2 ? t2 - {1'b0, dvs_reg} : t2;
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= deriv ? D_STEPS : I_STEPS;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: load on start, shift while busy
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg   <= hi_sel[31:0];
            sh_reg    <= deriv ? (dividend << D_SHIFT) : (dividend << I_SHIFT);
            q_reg     <= '0;
            ovf_reg   <= ovf_start;
            deriv_reg <= deriv;
            dvs_reg   <= divisor;
        end else if (busy_reg) begin
            rem_reg <= r2[31:0];
            sh_reg  <= sh_reg << 2;
            q_reg   <= {q_reg[DIV_QW-3:0], ge1, ge2};
        end
    end

    // Saturate the quotient
    assign lim  = deriv_reg ? D_LIM : I_LIM;
    assign quot = (ovf_reg || (q_reg > {1'b0, lim})) ? lim : q_reg[DIV_RW-1:0];

    assign busy = busy_reg;
    assign done = done_reg;

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a run");

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_cnt_live: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg != 5'd0)
        else $error("divider busy with empty step count");

endmodule

### rtl/pid_dpath.sv
module pid_dpath import pid_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pid_cmd_t              cmd,
    output pid_stat_t             stat,
    input  logic [S_DATA_W-1:0]   s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers
    logic signed [31:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [15:0] target_temp_reg;
    logic signed [31:0] out_low_reg, out_high_reg, int_low_reg, int_high_reg;

    // Controller state carried between requests
    logic signed [16:0] prev_err_reg;
    logic [31:0]        prev_time_reg;
    logic signed [47:0] acc_reg;

    // Per-request working registers
    logic signed [15:0] temp_reg;
    logic [31:0]        ts_reg;
    logic [31:0]        dt_reg;
    logic [15:0]        err_mag_reg;
    logic [16:0]        esum_mag_reg, ediff_mag_reg;
    logic               err_neg_reg, esum_neg_reg, ediff_neg_reg;
    logic [47:0]        pmag_reg;
    logic [48:0]        wide_reg;
    logic [63:0]        wlo_reg;
    logic [48:0]        whi_reg;
    logic signed [47:0] sum_reg;
    logic [31:0]        out_data_reg;
    logic               out_valid_reg;

    logic signed [16:0] err;
    logic signed [17:0] esum, ediff;
    logic [16:0]        err_abs;
    logic [17:0]        esum_abs, ediff_abs;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_p;
    logic [80:0]        wsum;
    logic               div_start, div_deriv, div_busy, div_done;
    logic [DIV_NW-1:0]  div_num;
    logic [31:0]        div_dvs;
    logic [DIV_RW-1:0]  div_q;
    logic signed [52:0] inc, acc_sum, ilim_lo, ilim_hi;
    logic signed [47:0] pterm, dterm, acc_bias, osum;
    logic signed [31:0] iterm;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        mag32 = v[31] ? 32'(-v) : 32'(v);
    endfunction

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg      <= '0;
            gain_i_reg      <= '0;
            gain_d_reg      <= '0;
            target_temp_reg <= 16'sd1600;
            out_low_reg     <= '0;
            out_high_reg    <= '0;
            int_low_reg     <= '0;
            int_high_reg    <= '0;
        end else if (cfg_valid) begin
            unique case (pid_reg_t'(cfg_index))
                REG_GAIN_P:      gain_p_reg      <= cfg_data;
                REG_GAIN_I:      gain_i_reg      <= cfg_data;
                REG_GAIN_D:      gain_d_reg      <= cfg_data;
                REG_TARGET_TEMP: target_temp_reg <= cfg_data[15:0];
                REG_OUT_LOW:     out_low_reg     <= cfg_data;
                REG_OUT_HIGH:    out_high_reg    <= cfg_data;
                REG_INT_LOW:     int_low_reg     <= cfg_data;
                REG_INT_HIGH:    int_high_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Error terms and elapsed time
    always_comb begin
        err       = {target_temp_reg[15], target_temp_reg} - {temp_reg[15], temp_reg};
        esum      = {err[16], err} + {prev_err_reg[16], prev_err_reg};
        ediff     = {err[16], err} - {prev_err_reg[16], prev_err_reg};
        err_abs   = err[16] ? 17'(-err) : 17'(err);
        esum_abs  = esum[17] ? 18'(-esum) : 18'(esum);
        ediff_abs = ediff[17] ? 18'(-ediff) : 18'(ediff);
    end

    // Shared 32x32 multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MUL_P: begin
                mul_a = mag32(gain_p_reg);
                mul_b = {16'b0, err_mag_reg};
            end
            OP_MUL_S: begin
                mul_a = dt_reg;
                mul_b = {15'b0, esum_mag_reg};
            end
            OP_MUL_ILO: begin
                mul_a = mag32(gain_i_reg);
                mul_b = wide_reg[31:0];
            end
            OP_MUL_IHI: begin
                mul_a = mag32(gain_i_reg);
                mul_b = {15'b0, wide_reg[48:32]};
            end
            OP_MUL_D: begin
                mul_a = mag32(gain_d_reg);
                mul_b = {15'b0, ediff_mag_reg};
            end
            OP_MUL_DLO: begin
                mul_a = wide_reg[31:0];
                mul_b = DER_SCALE;
            end
            OP_MUL_DHI: begin
                mul_a = {15'b0, wide_reg[48:32]};
                mul_b = DER_SCALE;
            end
            default: ;
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Combine partial products into the dividend
    assign wsum      = {whi_reg[48:0], 32'b0} + {17'b0, wlo_reg};
    assign div_start = (cmd.op == OP_DIV_I) || (cmd.op == OP_DIV_D);
    assign div_deriv = (cmd.op == OP_DIV_D);
    assign div_num   = div_deriv ? {5'b0, wsum} : {wsum, 5'b0};
    assign div_dvs   = div_deriv ? dt_reg : INT_DIVISOR;

    pid_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .deriv    (div_deriv),
        .dividend (div_num),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_q)
    );

    // Integral update with clamp; high limit wins
    always_comb begin
        inc     = (esum_neg_reg ^ gain_i_reg[31]) ? -$signed({2'b0, div_q})
                                                  : $signed({2'b0, div_q});
        acc_sum = {{5{acc_reg[47]}}, acc_reg} + inc;
        ilim_lo = {{5{int_low_reg[31]}}, int_low_reg, 16'b0};
        ilim_hi = {{5{int_high_reg[31]}}, int_high_reg, 16'b0};
    end

    // Terms of the sum, each truncated toward zero
    always_comb begin
        pterm    = err_neg_reg ^ gain_p_reg[31] ? -$signed({4'b0, pmag_reg[47:4]})
                                                : $signed({4'b0, pmag_reg[47:4]});
        acc_bias = acc_reg + (acc_reg[47] ? 48'sh00_0000_FFFF : 48'sh0);
        iterm    = acc_bias[47:16];
        if (stat.dt_zero) begin
            dterm = '0;
        end else if (ediff_neg_reg ^ gain_d_reg[31]) begin
            dterm = -$signed({1'b0, div_q[46:0]});
        end else begin
            dterm = $signed({1'b0, div_q[46:0]});
        end
        osum = pterm + {{16{iterm[31]}}, iterm} + dterm;
    end

    // State kept from one request to the next
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_err_reg  <= '0;
            prev_time_reg <= '0;
            acc_reg       <= '0;
        end else begin
            if (cmd.op == OP_PREP) begin
                prev_err_reg  <= err;
                prev_time_reg <= ts_reg;
            end
            if (cmd.op == OP_ACC) begin
                if (acc_sum > ilim_hi) begin
                    acc_reg <= ilim_hi[47:0];
                end else if (acc_sum < ilim_lo) begin
                    acc_reg <= ilim_lo[47:0];
                end else begin
                    acc_reg <= acc_sum[47:0];
                end
            end
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                temp_reg <= s_tdata[15:0];
                ts_reg   <= s_tdata[47:16];
            end
            OP_PREP: begin
                dt_reg        <= ts_reg - prev_time_reg;
                err_mag_reg   <= err_abs[15:0];
                err_neg_reg   <= err[16];
                esum_mag_reg  <= esum_abs[16:0];
                esum_neg_reg  <= esum[17];
                ediff_mag_reg <= ediff_abs[16:0];
                ediff_neg_reg <= ediff[17];
            end
            OP_MUL_P:   pmag_reg <= mul_p[47:0];
            OP_MUL_S:   wide_reg <= mul_p[48:0];
            OP_MUL_ILO: wlo_reg  <= mul_p;
            OP_MUL_IHI: whi_reg  <= mul_p[48:0];
            OP_MUL_D:   wide_reg <= mul_p[48:0];
            OP_MUL_DLO: wlo_reg  <= mul_p;
            OP_MUL_DHI: whi_reg  <= mul_p[48:0];
            OP_SUM:     sum_reg  <= osum;
            OP_OUT: begin
                if (sum_reg > $signed({{16{out_high_reg[31]}}, out_high_reg})) begin
                    out_data_reg <= out_high_reg;
                end else if (sum_reg < $signed({{16{out_low_reg[31]}}, out_low_reg})) begin
                    out_data_reg <= out_low_reg;
                end else begin
                    out_data_reg <= sum_reg[31:0];
                end
            end
            default: ;
        endcase
    end

    // Output register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.op == OP_OUT) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat.div_done = div_done;
    assign stat.dt_zero  = (dt_reg == 32'd0);
    assign stat.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_div_idle_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("division requested while divider busy");

    a_acc_in_limits: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(cmd.op == OP_ACC) &&
         ($signed($past(int_low_reg)) <= $signed($past(int_high_reg)))) |->
        (acc_reg <= $signed({$past(int_high_reg), 16'h0}) &&
         acc_reg >= $signed({$past(int_low_reg), 16'h0})))
        else $error("integral outside its limits");

    a_valid_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(cmd.op == OP_OUT))
        else $error("result shown without an output request");

endmodule

### rtl/pid_ctrl.sv
module pid_ctrl import pid_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  pid_stat_t stat,
    output pid_cmd_t  cmd
);

    typedef enum logic [14:0] {
        ST_IDLE    = 15'h0001,
        ST_PREP    = 15'h0002,
        ST_MUL_P   = 15'h0004,
        ST_MUL_S   = 15'h0008,
        ST_MUL_ILO = 15'h0010,
        ST_MUL_IHI = 15'h0020,
        ST_DIV_I   = 15'h0040,
        ST_WAIT_I  = 15'h0080,
        ST_ACC     = 15'h0100,
        ST_MUL_D   = 15'h0200,
        ST_MUL_DLO = 15'h0400,
        ST_MUL_DHI = 15'h0800,
        ST_DIV_D   = 15'h1000,
        ST_WAIT_D  = 15'h2000,
        ST_SUM     = 15'h4000
    } pid_state_t;

    pid_state_t state_reg, state_next;
    logic       out_wait_reg, out_wait_next;

    // Sequence one request through the datapath
    always_comb begin
        state_next    = state_reg;
        out_wait_next = out_wait_reg;
        cmd.op        = OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (out_wait_reg) begin
                    // Finished result waits for the output register
                    if (stat.out_free) begin
                        cmd.op        = OP_OUT;
                        out_wait_next = 1'b0;
                    end
                end else if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.op     = OP_PREP;
                state_next = ST_MUL_P;
            end
            ST_MUL_P: begin
                cmd.op     = OP_MUL_P;
                state_next = ST_MUL_S;
            end
            ST_MUL_S: begin
                cmd.op     = OP_MUL_S;
                state_next = ST_MUL_ILO;
            end
            ST_MUL_ILO: begin
                cmd.op     = OP_MUL_ILO;
                state_next = ST_MUL_IHI;
            end
            ST_MUL_IHI: begin
                cmd.op     = OP_MUL_IHI;
                state_next = ST_DIV_I;
            end
            ST_DIV_I: begin
                cmd.op     = OP_DIV_I;
                state_next = ST_WAIT_I;
            end
            ST_WAIT_I: begin
                if (stat.div_done) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                cmd.op     = OP_ACC;
                state_next = stat.dt_zero ? ST_SUM : ST_MUL_D;
            end
            ST_MUL_D: begin
                cmd.op     = OP_MUL_D;
                state_next = ST_MUL_DLO;
            end
            ST_MUL_DLO: begin
                cmd.op     = OP_MUL_DLO;
                state_next = ST_MUL_DHI;
            end
            ST_MUL_DHI: begin
                cmd.op     = OP_MUL_DHI;
                state_next = ST_DIV_D;
            end
            ST_DIV_D: begin
                cmd.op     = OP_DIV_D;
                state_next = ST_WAIT_D;
            end
            ST_WAIT_D: begin
                if (stat.div_done) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                cmd.op        = OP_SUM;
                out_wait_next = 1'b1;
                state_next    = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            out_wait_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            out_wait_reg <= out_wait_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE) && !out_wait_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> state_reg == ST_PREP)
        else $error("accepted request did not start");

    a_wait_on_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WAIT_I && !stat.div_done) |=> state_reg == ST_WAIT_I)
        else $error("left integral wait before division finished");

    a_no_accept_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        out_wait_reg |-> cmd.op != OP_LOAD)
        else $error("request accepted with a result pending");

endmodule

### rtl/pid_temperature_controller.sv
// PID temperature controller.
// s_ channel: one request per sample, s_tdata = temperature (Q12.4, bits 15:0)
//   and timestamp_us (bits 47:16). m_ channel: one drive command per request,
//   m_tdata = command (Q16.16, bits 31:0). cfg_ channel: write gains, setpoint
//   and limits by register index; always ready, write only between requests.
// Each request runs through a shared 32x32 multiplier (up to seven products) and a
//   shared restoring divider that retires two quotient bits a cycle: 52 quotient
//   bits for the integral increment, 46 for the derivative term.
// The derivative is skipped when the timestamp did not advance. A new request
//   is accepted the cycle after the previous command is written to the output
//   register, so a request is not taken while the previous one is in flight.
// The output register holds one command; a stalled receiver lets the next
//   request compute fully, and it then waits for the register to empty before
//   the block accepts again.
// Reset (aresetn low, synchronous) clears gains and limits, sets the setpoint
//   to 100 degrees, and zeroes the integral, last error and last timestamp.
module pid_temperature_controller import pid_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // [15:0] temperature, [47:16] timestamp_us
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // [31:0] command
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    pid_cmd_t  cmd;
    pid_stat_t stat;

    assign cfg_ready = 1'b1;

    pid_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pid_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

### test/pid_temperature_controller_tb.sv
`timescale 1ns / 1ps

module pid_temperature_controller_tb;
    import pid_pkg::*;

    localparam int          REQS_PER_PHASE = 125;
    localparam int          PHASES         = 6;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          DRAIN_CYCLES   = 80;
    localparam int unsigned LIMIT_CYCLES   = 400_000;
    localparam logic [127:0] INC_SAT       = 128'd1 << 50;
    localparam logic [127:0] DER_SAT       = 128'd1 << 44;

    // Flavor of a random register setting
    typedef enum {SET_NORMAL, SET_EXTREME, SET_SWAPPED} setting_t;

    // One directed row: a register write, or a sample with an optional typed command
    typedef struct packed {
        logic        is_write;
        pid_reg_t    reg_idx;
        logic [31:0] value;     // register data, or timestamp_us of a sample
        logic [15:0] temp;
        logic        typed;
        logic [31:0] cmd;
    } req_row_t;

    localparam int N_DIRECTED = 44;

    req_row_t directed_requests [N_DIRECTED] = '{
        // reset setting: zero gains and zero clamps give a zero command
        '{1'b0, REG_GAIN_P,      32'h0000_0000, 16'h0000, 1'b1, 32'h0000_0000},
        '{1'b0, REG_GAIN_P,      32'hFFFF_FFFF, 16'h7FFF, 1'b1, 32'h0000_0000},
        '{1'b0, REG_GAIN_P,      32'h0000_0001, 16'h8000, 1'b1, 32'h0000_0000},
        // modest gains, wide clamps
        '{1'b1, REG_OUT_LOW,     32'h8000_0000, 16'h0000, 1'b0, 32'h0000_0000},
        '{1'b1, REG_OUT_HIGH,    32'h7FFF_FFFF, 16'h0000, 1'b0, 32'h0000_0000},
        '{1'b1, REG_INT_LOW,     32'hFF9C_0000, 16'h0000, 1'b0, 32'h0000_0000},
        '{1'b1, REG_INT_HIGH,    32'h0064_0000, 16'h0000, 1'b0, 32'h0000_0000},
        '{1'b1, REG_GAIN_P,      32'h0001_0000, 16'h0000, 1'b0, 32'h0000_0000},
        '{1'b1, REG_GAIN_I,      32'h0000_8000, 16'h0000, 1'b0, 32'h0000_0000},
        '{1'b1, REG_GAIN_D,      32'h0000_0100, 16'h0000, 1'b0, 32'h0000_0000},
        '{1'b1, REG_TARGET_TEMP, 32'h0000_0640, 16'h0000, 1'b0, 32'h0000_0000},
        '{1'b0, REG_GAIN_P,      32'h0000_03E8, 16'h0640, 1'b0, 32'h0000_0000},
        '{1'b0, REG_GAIN_P,      32'h0000_07D0, 16'h0500, 1'b0, 32'h0000_0000},
        // same timestamp again: derivative drops out
        '{1'b0, REG_GAIN_P,      32'h0000_07D0, 16'h0500, 1'b0, 32'h0000_0000},
        '{1'b0, REG_GAIN_P,      32'h0001_0000, 16'h7FFF, 1'b0, 32'h0000_0000},
        '{1'b0, REG_GAIN_P,      32'h0002_0000, 16'h8000, 1'b0, 32'h0000_0000},
        '{1'b0, REG_GAIN_P,      32'hFFFF_FF00, 16'h0000, 1'b0, 32'h0000_0000},
        // timestamp wraps
        '{1'b0, REG_GAIN_P,      32'h0000_0100, 16'h0000, 1'b0, 32'h0000_0000},
        // full-scale integral and derivative gains: both terms saturate
        '{1'b1, REG_GAIN_I,      32'h7FFF_FFFF, 16'h0000, 1'b0, 32'h0000_0000},
        '{1'b1, REG_INT_LOW,     32'h8000_0000, 16'h0000, 1'b0, 32'h0000_0000},
        '{1'b1, REG_INT_HIGH,    32'h7FFF_FFFF, 16'h0000, 1'b0, 32'h0000_0000},
        '{1'b1, REG_GAIN_D,      32'h8000_0000, 16'h0000, 1'b0, 32'h0000_0000},
        '{1'b0, REG_GAIN_P,      32'h8000_0000, 16'h8000, 1'b0, 32'h0000_0000},
        '{1'b0, REG_GAIN_P,      32'h8000_0001, 16'h7FFF, 1'b0, 32'h0000_0000},
        '{1'b0, REG_GAIN_P,      32'h8000_0002, 16'h8000, 1'b0, 32'h0000_0000},
        // full proportional gain against narrow clamps
        '{1'b1, REG_GAIN_P,      32'h7FFF_FFFF, 16'h0000, 1'b0, 32'h0000_0000},
        '{1'b1, REG_GAIN_I,      32'h0000_0000, 16'h0000, 1'b0, 32'h0000_0000},
        '{1'b1, REG_GAIN_D,      32'h0000_0000, 16'h0000, 1'b0, 32'h0000_0000},
        '{1'b1, REG_OUT_LOW,     32'hFFFB_0000, 16'h0000, 1'b0, 32'h0000_0000},
        '{1'b1, REG_OUT_HIGH,    32'h0005_0000, 16'h0000, 1'b0, 32'h0000_0000},
        '{1'b0, REG_GAIN_P,      32'h8000_1000, 16'h8000, 1'b1, 32'h0005_0000},
        '{1'b0, REG_GAIN_P,      32'h8000_2000, 16'h7FFF, 1'b1, 32'hFFFB_0000},
        // low clamp above high clamp
        '{1'b1, REG_OUT_LOW,     32'h0000_0064, 16'h0000, 1'b0, 32'h0000_0000},
        '{1'b1, REG_OUT_HIGH,    32'hFFFF_FF9C, 16'h0000, 1'b0, 32'h0000_0000},
        '{1'b0, REG_GAIN_P,      32'h8000_3000, 16'h0640, 1'b0, 32'h0000_0000},
        '{1'b0, REG_GAIN_P,      32'h8000_4000, 16'h0000, 1'b1, 32'hFFFF_FF9C},
        // most negative gain and setpoint extremes
        '{1'b1, REG_GAIN_P,      32'h8000_0000, 16'h0000, 1'b0, 32'h0000_0000},
        '{1'b1, REG_TARGET_TEMP, 32'h0000_8000, 16'h0000, 1'b0, 32'h0000_0000},
        '{1'b1, REG_OUT_LOW,     32'h8000_0000, 16'h0000, 1'b0, 32'h0000_0000},
        '{1'b1, REG_OUT_HIGH,    32'h7FFF_FFFF, 16'h0000, 1'b0, 32'h0000_0000},
        '{1'b0, REG_GAIN_P,      32'h8000_5000, 16'h7FFF, 1'b1, 32'h7FFF_FFFF},
        '{1'b0, REG_GAIN_P,      32'h8000_6000, 16'h8000, 1'b0, 32'h0000_0000},
        '{1'b1, REG_TARGET_TEMP, 32'h0000_7FFF, 16'h0000, 1'b0, 32'h0000_0000},
        '{1'b0, REG_GAIN_P,      32'h8000_7000, 16'h8000, 1'b1, 32'h8000_0000}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;   // [15:0] temperature, [47:16] timestamp_us
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;          // [31:0] command
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Typed command riding along with the request; it replaces the predicted command
    logic                  row_typed = 1'b0;
    logic [31:0]           row_cmd   = '0;

    bit                    hold_pending = 1'b0;
    bit                    no_gaps      = 1'b0;
    int                    errors       = 0;
    int                    accepted     = 0;
    int                    checked      = 0;
    int                    reg_writes   = 0;
    int unsigned           cycles       = 0;
    logic [31:0]           want_cmd;
    logic [31:0]           expected_cmds[$];

    // Controller shadow: registers and running state
    longint      kp = 0, ki = 0, kd = 0, setpoint = 1600;
    longint      cmd_lo = 0, cmd_hi = 0, integ_lo = 0, integ_hi = 0;
    longint      last_err = 0, integ = 0;
    logic [31:0] last_ts = '0;

    pid_temperature_controller u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic longint magnitude(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic longint bound(input longint v, input longint lo, input longint hi);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Advance the controller by one sample and return the clamped command
    function automatic logic [31:0] compute_command(input logic signed [15:0] temp,
                                                    input logic [31:0] ts);
        logic [31:0]  dt;
        logic [127:0] num, quot;
        longint       dt_l, err, trap, diff, pterm, inc, iterm, dterm, total;
        bit           neg;
        dt    = ts - last_ts;
        dt_l  = dt;
        err   = setpoint - temp;
        pterm = (kp * err) / 16;

        // trapezoid times dt, scaled by 32/15625 into Q16.32, saturated
        trap = (err + last_err) * dt_l;
        neg  = (trap < 0) != (ki < 0);
        num  = 128'(magnitude(ki) * 32) * 128'(magnitude(trap));
        quot = num / 128'd15625;
        if (quot > INC_SAT) quot = INC_SAT;
        inc   = neg ? -$signed(quot[63:0]) : $signed(quot[63:0]);
        integ = bound(integ + inc, integ_lo * 65536, integ_hi * 65536);
        iterm = integ / 65536;

        // error slope times 62500/dt, saturated; nothing when time stands still
        dterm = 0;
        if (dt != 0) begin
            diff = kd * (err - last_err);
            num  = 128'(magnitude(diff)) * 128'd62500;
            quot = num / {96'd0, dt};
            if (quot > DER_SAT) quot = DER_SAT;
            dterm = (diff < 0) ? -$signed(quot[63:0]) : $signed(quot[63:0]);
        end

        total    = bound(pterm + iterm + dterm, cmd_lo, cmd_hi);
        last_ts  = ts;
        last_err = err;
        return total[31:0];
    endfunction

    // Track register writes, predict on each accepted request, check each command
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                reg_writes++;
                case (pid_reg_t'(cfg_index))
                    REG_GAIN_P:      kp       = $signed(cfg_data);
                    REG_GAIN_I:      ki       = $signed(cfg_data);
                    REG_GAIN_D:      kd       = $signed(cfg_data);
                    REG_TARGET_TEMP: setpoint = $signed(cfg_data[15:0]);
                    REG_OUT_LOW:     cmd_lo   = $signed(cfg_data);
                    REG_OUT_HIGH:    cmd_hi   = $signed(cfg_data);
                    REG_INT_LOW:     integ_lo = $signed(cfg_data);
                    REG_INT_HIGH:    integ_hi = $signed(cfg_data);
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                want_cmd = compute_command(s_tdata[15:0], s_tdata[47:16]);
                if (row_typed) want_cmd = row_cmd;
                expected_cmds.push_back(want_cmd);
                accepted++;
            end
            if (m_tvalid && m_tready) begin
                if (expected_cmds.size() == 0) begin
                    $display("%0t: unexpected command %h", $time, m_tdata);
                    errors++;
                end else begin
                    want_cmd = expected_cmds.pop_front();
                    checked++;
                    if (m_tdata !== want_cmd) begin
                        $display("%0t: command mismatch, expected %h, got %h",
                                 $time, want_cmd, m_tdata);
                        errors++;
                    end
                end
            end
        end
    end

    // Receiver: random stalls, one long hold-off on request
    always begin
        @(negedge aclk);
        if (hold_pending) begin
            m_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge aclk);
            hold_pending = 1'b0;
        end
        m_tready <= no_gaps || ($urandom_range(99) >= 11);
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_request(input logic [15:0] temp, input logic [31:0] ts,
                                input logic typed, input logic [31:0] cmd);
        @(negedge aclk);
        while (!no_gaps && $urandom_range(99) < 11) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= {ts, temp};
        row_typed <= typed;
        row_cmd   <= cmd;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(input pid_reg_t idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Drop the request line and wait for every outstanding command
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_cmds.size() != 0) @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_gain(input setting_t mode);
        logic [31:0] w;
        w = $urandom();
        if (mode == SET_EXTREME) begin
            case ($urandom_range(3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0000;
                default: return w;
            endcase
        end
        // mostly within +-4.0 so commands land between the clamps
        if ($urandom_range(9) == 0) return w;
        return {{13{w[18]}}, w[18:0]};
    endfunction

    function automatic void pick_limits(input setting_t mode,
                                        output logic [31:0] lo, output logic [31:0] hi);
        logic [31:0] a, b;
        a = $urandom();
        b = $urandom();
        case (mode)
            SET_EXTREME: begin
                lo = 32'h8000_0000;
                hi = 32'h7FFF_FFFF;
            end
            SET_SWAPPED: begin
                lo = {6'h00, a[25:0]};
                hi = {6'h3F, b[25:0]};
            end
            default: begin
                lo = {6'h3F, a[25:0]};
                hi = {6'h00, b[25:0]};
            end
        endcase
    endfunction

    task automatic apply_random_setting(input setting_t mode);
        logic [31:0] lo, hi;
        write_reg(REG_GAIN_P, pick_gain(mode));
        write_reg(REG_GAIN_I, pick_gain(mode));
        write_reg(REG_GAIN_D, pick_gain(mode));
        if (mode == SET_EXTREME)
            write_reg(REG_TARGET_TEMP, $urandom_range(1) ? 32'h0000_7FFF : 32'hFFFF_8000);
        else
            write_reg(REG_TARGET_TEMP, {16'h0, 16'h0440 + 16'($urandom_range(1024))});
        pick_limits(mode, lo, hi);
        write_reg(REG_OUT_LOW, lo);
        write_reg(REG_OUT_HIGH, hi);
        pick_limits((mode == SET_NORMAL) ? setting_t'($urandom_range(2)) : mode, lo, hi);
        write_reg(REG_INT_LOW, lo);
        write_reg(REG_INT_HIGH, hi);
    endtask

    initial begin
        setting_t    mode;
        logic [15:0] temp;
        logic [31:0] now_us;
        logic [31:0] w;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Walk the directed rows
        for (int i = 0; i < N_DIRECTED; i++) begin
            if (directed_requests[i].is_write) begin
                settle();
                write_reg(directed_requests[i].reg_idx, directed_requests[i].value);
            end else begin
                send_request(directed_requests[i].temp, directed_requests[i].value,
                             directed_requests[i].typed, directed_requests[i].cmd);
            end
        end

        // Random phases: a fresh setting each, then a stream of samples
        now_us = 32'h8000_8000;
        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            mode = (phase % 4 == 1) ? SET_EXTREME : (phase == 3) ? SET_SWAPPED : SET_NORMAL;
            apply_random_setting(mode);
            no_gaps = (phase == 4);
            for (int n = 0; n < REQS_PER_PHASE; n++) begin
                if (phase == 2 && n == 10) hold_pending = 1'b1;
                w = $urandom();
                case ($urandom_range(19))
                    0: begin
                        temp   = w[15:0];
                        now_us = $urandom();
                    end
                    1: temp = 16'(setpoint) + {{9{w[6]}}, w[6:0]};
                    2: begin
                        temp   = w[15:0];
                        now_us = now_us + $urandom_range(1, 100000);
                    end
                    default: begin
                        temp   = 16'(setpoint) + {{9{w[6]}}, w[6:0]};
                        now_us = now_us + $urandom_range(1, 100000);
                    end
                endcase
                send_request(temp, now_us, 1'b0, 32'h0);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_cmds.size() != 0) errors++;

        $display("Checked %0d commands for %0d samples over %0d register writes.",
                 checked, accepted, reg_writes);
        $display("Covered clamp extremes, swapped limits, repeated and wrapping timestamps,");
        $display("and a %0d-cycle output stall with the input backed up.", HOLD_CYCLES);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
